// File: rtl/cbut_pkg.sv
// Shared types, constants and CRC function for the cell balancer telemetry block.
package cbut_pkg;

   localparam int FRAME_BYTES   = 8;
   localparam int BITS_PER_CHAR = 10;

   localparam logic [7:0] FRAME_START = 8'h3E;
   localparam logic [7:0] FRAME_END   = 8'hEE;
   localparam logic [7:0] CRC_POLY    = 8'h8C;

   // Configuration register indexes
   localparam logic [2:0] CSR_REF_LEVEL     = 3'd0;
   localparam logic [2:0] CSR_DUTY_TOP      = 3'd1;
   localparam logic [2:0] CSR_CONV_PERIOD   = 3'd2;
   localparam logic [2:0] CSR_BLANK_TICKS   = 3'd3;
   localparam logic [2:0] CSR_REPORT_PERIOD = 3'd4;
   localparam logic [2:0] CSR_TICKS_PER_BIT = 3'd5;

   // Frame byte positions
   localparam logic [2:0] BYTE_START     = 3'd0;
   localparam logic [2:0] BYTE_SAMPLE_HI = 3'd1;
   localparam logic [2:0] BYTE_SAMPLE_LO = 3'd2;
   localparam logic [2:0] BYTE_REF_HI    = 3'd3;
   localparam logic [2:0] BYTE_REF_LO    = 3'd4;
   localparam logic [2:0] BYTE_DUTY      = 3'd5;
   localparam logic [2:0] BYTE_CRC       = 3'd6;
   localparam logic [2:0] BYTE_END       = 3'd7;

   localparam logic [15:0] RESET_REF_LEVEL     = 16'd0;
   localparam logic [7:0]  RESET_DUTY_TOP      = 8'd165;
   localparam logic [7:0]  RESET_CONV_PERIOD   = 8'd36;
   localparam logic [7:0]  RESET_BLANK_TICKS   = 8'd9;
   localparam logic [15:0] RESET_REPORT_PERIOD = 16'd360;
   localparam logic [3:0]  RESET_TICKS_PER_BIT = 4'd3;

   typedef struct packed {
      logic [7:0] conv_period;
      logic [7:0] blank_ticks;
      logic [15:0] report_period;
   } timer_cfg_type;

   typedef struct packed {
      logic [15:0] ref_level;
      logic [7:0] duty_top;
      logic [3:0] ticks_per_bit;
   } telem_cfg_type;

   typedef struct packed {
      logic pwm_blank;
      logic adc_start;
      logic report_due;
   } timer_status_type;

   typedef struct packed {
      logic tx_line;
      logic [7:0] duty;
      logic tx_busy;
   } telem_status_type;

   // One byte of Dallas/Maxim CRC-8, reflected, eight shift steps
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   localparam logic [7:0] CRC_AFTER_START = crc8_step(8'h00, FRAME_START);

endpackage

// File: rtl/cbut_timer.sv
// Measurement cycle and report period counters with blanking and ADC start logic.
module cbut_timer
   import cbut_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             tick,
   input  timer_cfg_type    cfg,
   output timer_status_type status
);

   logic [7:0]  cycle_ff, cycle_in, cycle_inc;
   logic [15:0] report_ff, report_in, report_inc;
   logic        armed_ff, armed_in;
   logic        blank;
   logic        due;

   // Advance counters on a tick, wrapping at their periods
   always_comb begin
      cycle_inc  = cycle_ff + 8'd1;
      report_inc = report_ff + 16'd1;
      cycle_in   = cycle_ff;
      report_in  = report_ff;
      due        = 1'b0;
      if (tick) begin
         cycle_in  = (cycle_inc >= cfg.conv_period) ? 8'd0 : cycle_inc;
         if (report_inc >= cfg.report_period) begin
            report_in = 16'd0;
            due       = 1'b1;
         end else begin
            report_in = report_inc;
         end
      end
   end

   // Blank while inside the window; pulse start on the first tick after it
   always_comb begin
      blank             = (cycle_in <= cfg.blank_ticks);
      status.pwm_blank  = blank;
      status.adc_start  = tick && !blank && !armed_ff;
      status.report_due = due;
      armed_in          = tick ? !blank : armed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ff  <= '0;
         report_ff <= '0;
         armed_ff  <= 1'b0;
      end else begin
         cycle_ff  <= cycle_in;
         report_ff <= report_in;
         armed_ff  <= armed_in;
      end
   end

endmodule

// File: rtl/cbut_telem.sv
// Duty stepping, frame capture, running CRC and 8N1 serial transmitter.
module cbut_telem
   import cbut_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             tick,
   input  logic             report_due,
   input  logic [9:0]       last_sample,
   input  telem_cfg_type    cfg,
   output telem_status_type status
);

   logic [3:0]  idx_ff, idx_in, idx_inc;
   logic [9:0]  shift_ff, shift_in;
   logic [3:0]  bits_ff, bits_in, bits_dec;
   logic [3:0]  timer_ff, timer_in;
   logic        active_ff, active_in;
   logic        pending_ff, pending_in, pending_any;
   logic        line_ff, line_in;
   logic [7:0]  duty_ff, duty_in;
   logic [7:0]  crc_ff, crc_in;
   logic [9:0]  snap_sample_ff, snap_sample_in;
   logic [15:0] snap_ref_ff, snap_ref_in;
   logic [7:0]  snap_duty_ff, snap_duty_in;
   logic [7:0]  next_byte;

   // Select the frame byte at the next index
   always_comb begin
      idx_inc = idx_ff + 4'd1;
      case (idx_inc[2:0])
         BYTE_START:     next_byte = FRAME_START;
         BYTE_SAMPLE_HI: next_byte = {6'd0, snap_sample_ff[9:8]};
         BYTE_SAMPLE_LO: next_byte = snap_sample_ff[7:0];
         BYTE_REF_HI:    next_byte = snap_ref_ff[15:8];
         BYTE_REF_LO:    next_byte = snap_ref_ff[7:0];
         BYTE_DUTY:      next_byte = snap_duty_ff;
         BYTE_CRC:       next_byte = crc_ff;
         BYTE_END:       next_byte = FRAME_END;
         default:        next_byte = FRAME_END;
      endcase
   end

   always_comb begin
      idx_in         = idx_ff;
      shift_in       = shift_ff;
      bits_in        = bits_ff;
      timer_in       = timer_ff;
      active_in      = active_ff;
      pending_in     = pending_ff;
      line_in        = line_ff;
      duty_in        = duty_ff;
      crc_in         = crc_ff;
      snap_sample_in = snap_sample_ff;
      snap_ref_in    = snap_ref_ff;
      snap_duty_in   = snap_duty_ff;
      bits_dec       = bits_ff - 4'd1;
      pending_any    = pending_ff || report_due;

      if (tick) begin
         // Advance the transmitter by one tick
         if (active_ff) begin
            if (timer_ff > 4'd1) begin
               timer_in = timer_ff - 4'd1;
            end else begin
               line_in  = shift_ff[0];
               shift_in = shift_ff >> 1;
               timer_in = cfg.ticks_per_bit;
               bits_in  = bits_dec;
               if (bits_dec == 4'd0) begin
                  idx_in = idx_inc;
                  if (idx_inc < 4'(FRAME_BYTES)) begin
                     shift_in = {1'b1, next_byte, 1'b0};
                     bits_in  = 4'(BITS_PER_CHAR);
                     // Fold data bytes into the running CRC as they go out
                     if (idx_inc[2:0] < BYTE_CRC) begin
                        crc_in = crc8_step(crc_ff, next_byte);
                     end
                  end else begin
                     active_in = 1'b0;
                  end
               end
            end
         end

         // Run a due report once the line is free
         pending_in = pending_any;
         if (pending_any && !active_in) begin
            pending_in = 1'b0;
            if ({6'd0, last_sample} > cfg.ref_level) begin
               if (duty_ff < cfg.duty_top) begin
                  duty_in = duty_ff + 8'd1;
               end
            end else if (duty_ff != 8'd0) begin
               duty_in = duty_ff - 8'd1;
            end
            snap_sample_in = last_sample;
            snap_ref_in    = cfg.ref_level;
            snap_duty_in   = duty_in;
            crc_in         = CRC_AFTER_START;
            idx_in         = 4'd0;
            shift_in       = {1'b1, FRAME_START, 1'b0};
            bits_in        = 4'(BITS_PER_CHAR);
            timer_in       = cfg.ticks_per_bit;
            active_in      = 1'b1;
         end
      end
   end

   assign status = '{tx_line: line_in, duty: duty_in, tx_busy: active_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         shift_ff   <= '0;
         bits_ff    <= '0;
         timer_ff   <= '0;
         active_ff  <= 1'b0;
         pending_ff <= 1'b0;
         line_ff    <= 1'b1;
         duty_ff    <= '0;
      end else begin
         idx_ff     <= idx_in;
         shift_ff   <= shift_in;
         bits_ff    <= bits_in;
         timer_ff   <= timer_in;
         active_ff  <= active_in;
         pending_ff <= pending_in;
         line_ff    <= line_in;
         duty_ff    <= duty_in;
      end
   end

   // Frame contents; read only while a frame is active
   always_ff @(posedge clock) begin
      crc_ff         <= crc_in;
      snap_sample_ff <= snap_sample_in;
      snap_ref_ff    <= snap_ref_in;
      snap_duty_ff   <= snap_duty_in;
   end

endmodule

// File: rtl/cell_balancer_uart_telemetry.sv
// Top level of the cell balancer with serial CRC-8 telemetry.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_operation, req_sample
//   rsp      out        rsp_valid/rsp_stall  rsp_tx_line, rsp_duty, rsp_pwm_blank,
//                                            rsp_adc_start, rsp_tx_busy
//   csr      in         csr_wr_en            csr_index, csr_wr_data
//
// Each request is processed in the cycle it is accepted and its response sits in
// the output register on the next cycle: one request per cycle while req_stall is low.
// A request is accepted whenever the output register is empty or being taken.
// Reset is synchronous; it loads the register defaults and clears all control state.
// While rsp_stall holds a full output register, req_stall is raised.
module cell_balancer_uart_telemetry
   import cbut_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [9:0]  req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_line,
   output logic [7:0]  rsp_duty,
   output logic        rsp_pwm_blank,
   output logic        rsp_adc_start,
   output logic        rsp_tx_busy,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   logic [15:0] ref_level_ff;
   logic [7:0]  duty_top_ff;
   logic [7:0]  conv_period_ff;
   logic [7:0]  blank_ticks_ff;
   logic [15:0] report_period_ff;
   logic [3:0]  ticks_per_bit_ff;
   logic [9:0]  sample_ff, sample_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        line_ff, blank_ff, start_ff, busy_ff;
   logic [7:0]  duty_ff;
   logic        accept, tick;

   timer_cfg_type    timer_cfg;
   telem_cfg_type    telem_cfg;
   timer_status_type timer_status;
   telem_status_type telem_status;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_level_ff     <= RESET_REF_LEVEL;
         duty_top_ff      <= RESET_DUTY_TOP;
         conv_period_ff   <= RESET_CONV_PERIOD;
         blank_ticks_ff   <= RESET_BLANK_TICKS;
         report_period_ff <= RESET_REPORT_PERIOD;
         ticks_per_bit_ff <= RESET_TICKS_PER_BIT;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_REF_LEVEL:     ref_level_ff     <= csr_wr_data;
            CSR_DUTY_TOP:      duty_top_ff      <= csr_wr_data[7:0];
            CSR_CONV_PERIOD:   conv_period_ff   <= csr_wr_data[7:0];
            CSR_BLANK_TICKS:   blank_ticks_ff   <= csr_wr_data[7:0];
            CSR_REPORT_PERIOD: report_period_ff <= csr_wr_data;
            CSR_TICKS_PER_BIT: ticks_per_bit_ff <= csr_wr_data[3:0];
            default: ;
         endcase
      end
   end

   assign timer_cfg = '{conv_period: conv_period_ff, blank_ticks: blank_ticks_ff,
                        report_period: report_period_ff};
   assign telem_cfg = '{ref_level: ref_level_ff, duty_top: duty_top_ff,
                        ticks_per_bit: ticks_per_bit_ff};

   // Accept a request unless a held response blocks the output register
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign tick      = accept && !req_operation;

   // Keep the latest ADC sample
   assign sample_in = (accept && req_operation) ? req_sample : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   cbut_timer u_timer (
      .clock  (clock),
      .reset  (reset),
      .tick   (tick),
      .cfg    (timer_cfg),
      .status (timer_status)
   );

   cbut_telem u_telem (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick),
      .report_due  (timer_status.report_due),
      .last_sample (sample_ff),
      .cfg         (telem_cfg),
      .status      (telem_status)
   );

   // Output register: load on accept, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         line_ff  <= telem_status.tx_line;
         duty_ff  <= telem_status.duty;
         busy_ff  <= telem_status.tx_busy;
         blank_ff <= timer_status.pwm_blank;
         start_ff <= timer_status.adc_start;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_line   = line_ff;
   assign rsp_duty      = duty_ff;
   assign rsp_pwm_blank = blank_ff;
   assign rsp_adc_start = start_ff;
   assign rsp_tx_busy   = busy_ff;

endmodule
